@@ sv/bfpt_pkg.sv @@
// ----------------------------------------------------------------------------
// bfpt_pkg
// shared types and constants for the backbone frame point transform
// ----------------------------------------------------------------------------
package bfpt_pkg;

  // unit vectors are signed q30
  localparam int UNIT_BITS = 30;
  localparam int UNIT_W    = UNIT_BITS + 2;
  localparam int VEC_W     = 64;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [UNIT_W-1:0] unit_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN,
    CFG_AXIS,
    CFG_PLANE
  } cfg_idx_t;

  typedef struct packed {
    logic busy;
    logic degenerate;
  } frame_stat_t;

endpackage

@@ sv/bfpt_frame.sv @@
// ----------------------------------------------------------------------------
// bfpt_frame
// builds the orthonormal frame from the three anchors with one shared
// multiplier, a bit-serial square root and a bit-serial divider
// ----------------------------------------------------------------------------
module bfpt_frame #(
  parameter int COORD_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [COORD_WIDTH-1:0] org_c   [3],
  input  logic signed [COORD_WIDTH-1:0] axis_c  [3],
  input  logic signed [COORD_WIDTH-1:0] plane_c [3],
  output bfpt_pkg::unit_t               ex_o    [3],
  output bfpt_pkg::unit_t               ey_o    [3],
  output bfpt_pkg::unit_t               ez_o    [3],
  output bfpt_pkg::frame_stat_t         stat_o
);

  localparam int VW = bfpt_pkg::VEC_W;
  localparam int UB = bfpt_pkg::UNIT_BITS;
  localparam int UW = bfpt_pkg::UNIT_W;
  localparam int DW = COORD_WIDTH + 1;

  typedef enum logic [3:0] {
    F_DONE, F_LOAD, F_MAG, F_NORM, F_SQ, F_SQRT, F_DIVLD, F_DIV, F_CROSS, F_ROUND
  } fstate_t;

  typedef enum logic [1:0] {PH_EX, PH_ET, PH_EZ, PH_EY} phase_t;

  fstate_t                state_r;
  phase_t                 phase_r;
  logic                   degen_r;
  logic [4:0]             cnt_r;
  logic [1:0]             comp_r;
  logic signed [VW-1:0]   vec_r  [3];
  logic [VW-1:0]          mag_r  [3];
  logic signed [VW-1:0]   prod_r;
  logic [VW-1:0]          acc_r;
  logic [VW-1:0]          root_r;
  logic [31:0]            rem_r;
  logic [UB:0]            num_lo_r;
  logic [UB:0]            quo_r;
  bfpt_pkg::unit_t        ex_r [3];
  bfpt_pkg::unit_t        et_r [3];
  bfpt_pkg::unit_t        ez_r [3];
  bfpt_pkg::unit_t        ey_r [3];

  logic signed [DW-1:0]   toward [3];
  logic signed [DW-1:0]   across [3];
  logic [VW-1:0]          mag_vec [3];
  logic [VW-1:0]          rnd_sum [3];
  logic [VW-1:0]          top_m;
  logic                   vec_zero;
  logic                   norm_hi;
  logic                   norm_lo;
  bfpt_pkg::unit_t        p_v [3];
  bfpt_pkg::unit_t        q_v [3];
  bfpt_pkg::unit_t        mul_a;
  bfpt_pkg::unit_t        mul_b;
  logic signed [VW-1:0]   mul_p;
  logic [VW-1:0]          sq_bit;
  logic [VW-1:0]          sq_trial;
  logic                   sq_take;
  logic [32:0]            div_t;
  logic                   div_take;
  logic [31:0]            div_rem;
  logic [UB:0]            q_fin;
  bfpt_pkg::unit_t        u_val;
  logic [VW-1:0]          num_init;
  logic [2:0]             jj;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      toward[a]  = DW'(axis_c[a]) - DW'(org_c[a]);
      across[a]  = DW'(plane_c[a]) - DW'(org_c[a]);
      mag_vec[a] = vec_r[a][VW-1] ? VW'(-vec_r[a]) : VW'(vec_r[a]);
      rnd_sum[a] = mag_vec[a] + (VW'(1) << (UB - 1));
      p_v[a]     = (phase_r == PH_EY) ? ez_r[a] : ex_r[a];
      q_v[a]     = (phase_r == PH_EY) ? ex_r[a] : et_r[a];
    end
    vec_zero = (vec_r[0] == '0) && (vec_r[1] == '0) && (vec_r[2] == '0);
    top_m    = mag_r[0];
    if (mag_r[1] > top_m) top_m = mag_r[1];
    if (mag_r[2] > top_m) top_m = mag_r[2];
    norm_hi  = top_m >= (VW'(1) << UB);
    norm_lo  = top_m < (VW'(1) << (UB - 1));
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      F_SQ: begin
        case (cnt_r)
          5'd0: begin
            mul_a = UW'(mag_r[0][UB-1:0]);
            mul_b = UW'(mag_r[0][UB-1:0]);
          end
          5'd1: begin
            mul_a = UW'(mag_r[1][UB-1:0]);
            mul_b = UW'(mag_r[1][UB-1:0]);
          end
          5'd2: begin
            mul_a = UW'(mag_r[2][UB-1:0]);
            mul_b = UW'(mag_r[2][UB-1:0]);
          end
          default: ;
        endcase
      end
      F_CROSS: begin
        case (cnt_r)
          5'd0: begin mul_a = p_v[1]; mul_b = q_v[2]; end
          5'd1: begin mul_a = p_v[2]; mul_b = q_v[1]; end
          5'd2: begin mul_a = p_v[2]; mul_b = q_v[0]; end
          5'd3: begin mul_a = p_v[0]; mul_b = q_v[2]; end
          5'd4: begin mul_a = p_v[0]; mul_b = q_v[1]; end
          5'd5: begin mul_a = p_v[1]; mul_b = q_v[0]; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    sq_bit   = VW'(1) << (6'd62 - {cnt_r, 1'b0});
    sq_trial = root_r + sq_bit;
    sq_take  = acc_r >= sq_trial;
    div_t    = {rem_r, num_lo_r[UB]};
    div_take = div_t >= {1'b0, root_r[31:0]};
    div_rem  = div_take ? 32'(div_t - {1'b0, root_r[31:0]}) : div_t[31:0];
    q_fin    = {quo_r[UB-1:0], div_take};
    u_val    = vec_r[comp_r][VW-1] ? -UW'(q_fin) : UW'(q_fin);
    num_init = (VW'(mag_r[comp_r][UB-1:0]) << UB) + (root_r >> 1);
    jj       = cnt_r[2:0] - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_DONE;
      phase_r <= PH_EX;
      degen_r <= 1'b1;
      cnt_r   <= '0;
      comp_r  <= '0;
    end else begin
      prod_r <= mul_p;
      if (start) begin
        state_r <= F_LOAD;
        phase_r <= PH_EX;
        degen_r <= 1'b0;
      end else begin
        case (state_r)
          F_LOAD: begin
            for (int a = 0; a < 3; a++) begin
              vec_r[a] <= (phase_r == PH_EX) ? VW'(toward[a]) : VW'(across[a]);
            end
            state_r <= F_MAG;
          end
          F_MAG: begin
            if (vec_zero) begin
              degen_r <= 1'b1;
              state_r <= F_DONE;
            end else begin
              for (int a = 0; a < 3; a++) mag_r[a] <= mag_vec[a];
              state_r <= F_NORM;
            end
          end
          F_NORM: begin
            if (norm_hi) begin
              for (int a = 0; a < 3; a++) mag_r[a] <= mag_r[a] >> 1;
            end else if (norm_lo) begin
              for (int a = 0; a < 3; a++) mag_r[a] <= mag_r[a] << 1;
            end else begin
              acc_r   <= '0;
              cnt_r   <= '0;
              state_r <= F_SQ;
            end
          end
          F_SQ: begin
            if (cnt_r != 5'd0) acc_r <= acc_r + VW'(prod_r);
            if (cnt_r == 5'd3) begin
              cnt_r   <= '0;
              root_r  <= '0;
              state_r <= F_SQRT;
            end else begin
              cnt_r <= cnt_r + 5'd1;
            end
          end
          F_SQRT: begin
            if (sq_take) begin
              acc_r  <= acc_r - sq_trial;
              root_r <= (root_r >> 1) + sq_bit;
            end else begin
              root_r <= root_r >> 1;
            end
            if (cnt_r == 5'd31) begin
              comp_r  <= '0;
              state_r <= F_DIVLD;
            end
            cnt_r <= cnt_r + 5'd1;
          end
          F_DIVLD: begin
            rem_r    <= num_init[UB+32:UB+1];
            num_lo_r <= num_init[UB:0];
            quo_r    <= '0;
            cnt_r    <= '0;
            state_r  <= F_DIV;
          end
          F_DIV: begin
            rem_r    <= div_rem;
            num_lo_r <= num_lo_r << 1;
            quo_r    <= q_fin;
            cnt_r    <= cnt_r + 5'd1;
            if (cnt_r == 5'(UB)) begin
              case (phase_r)
                PH_EX:   ex_r[comp_r] <= u_val;
                PH_ET:   et_r[comp_r] <= u_val;
                PH_EZ:   ez_r[comp_r] <= u_val;
                default: ;
              endcase
              if (comp_r == 2'd2) begin
                cnt_r <= '0;
                case (phase_r)
                  PH_EX: begin
                    phase_r <= PH_ET;
                    state_r <= F_LOAD;
                  end
                  PH_ET: begin
                    phase_r <= PH_EZ;
                    state_r <= F_CROSS;
                  end
                  PH_EZ: begin
                    phase_r <= PH_EY;
                    state_r <= F_CROSS;
                  end
                  default: state_r <= F_DONE;
                endcase
              end else begin
                comp_r  <= comp_r + 2'd1;
                state_r <= F_DIVLD;
              end
            end
          end
          F_CROSS: begin
            if (cnt_r != 5'd0) begin
              vec_r[jj[2:1]] <= jj[0] ? vec_r[jj[2:1]] - prod_r : prod_r;
            end
            if (cnt_r == 5'd6) begin
              cnt_r   <= '0;
              state_r <= (phase_r == PH_EY) ? F_ROUND : F_MAG;
            end else begin
              cnt_r <= cnt_r + 5'd1;
            end
          end
          F_ROUND: begin
            for (int a = 0; a < 3; a++) begin
              ey_r[a] <= vec_r[a][VW-1] ? -UW'(rnd_sum[a][UB+UW-1:UB])
                                        : UW'(rnd_sum[a][UB+UW-1:UB]);
            end
            state_r <= F_DONE;
          end
          default: ;
        endcase
      end
    end
  end

  assign ex_o              = ex_r;
  assign ey_o              = ey_r;
  assign ez_o              = ez_r;
  assign stat_o.busy       = (state_r != F_DONE);
  assign stat_o.degenerate = degen_r;

endmodule

@@ sv/backbone_frame_point_transform.sv @@
// ----------------------------------------------------------------------------
// backbone_frame_point_transform
// places local points into the frame spanned by three anchor points
// ----------------------------------------------------------------------------
// the anchors origin, axis point and plane point are written through the
// cfg_we / cfg_index / cfg_wdata port; index 3 is ignored. every write to
// one of them restarts the frame builder, which finishes sooner
// when the frame turns out degenerate (one shared multiplier, a 32-step
// square root and a 31-step divider per axis component); in_ready stays low
// until it is done.
// after reset all anchors are zero, the frame is degenerate and the block
// is ready at once.
// points then stream one per cycle through a 4-stage pipeline: products,
// sums, rounding, then origin add and clipping into the output register.
// each accepted point moves through the products, the sums and the rounding
// into the output register, which then offers it as an output transaction.
// a stalled receiver holds the output register; the earlier stages keep
// filling until the pipeline is full, then in_ready drops. a degenerate
// frame gives zero coordinates with degenerate_frame set.
// ----------------------------------------------------------------------------
module backbone_frame_point_transform #(
  parameter  int COORD_WIDTH = 20,
  localparam int CFG_W       = (3 * COORD_WIDTH > 64) ? 64 : 3 * COORD_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [bfpt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]                     cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COORD_WIDTH-1:0]        in_point_x,
  input  logic signed [COORD_WIDTH-1:0]        in_point_y,
  input  logic signed [COORD_WIDTH-1:0]        in_point_z,
  input  logic                                 in_last_point,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [COORD_WIDTH-1:0]        out_out_x,
  output logic signed [COORD_WIDTH-1:0]        out_out_y,
  output logic signed [COORD_WIDTH-1:0]        out_out_z,
  output logic                                 out_degenerate_frame,
  output logic                                 out_saturated,
  output logic                                 out_last_out
);

  localparam int UB = bfpt_pkg::UNIT_BITS;
  localparam int UW = bfpt_pkg::UNIT_W;
  localparam int PW = COORD_WIDTH + UW;
  localparam int SW = PW + 2;
  localparam int RW = COORD_WIDTH + 6;
  localparam int VW = RW + 1;
  localparam logic signed [COORD_WIDTH-1:0] C_HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] C_LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic [CFG_W-1:0]              origin_r;
  logic [CFG_W-1:0]              axis_r;
  logic [CFG_W-1:0]              plane_r;
  logic signed [COORD_WIDTH-1:0] org_c   [3];
  logic signed [COORD_WIDTH-1:0] axis_c  [3];
  logic signed [COORD_WIDTH-1:0] plane_c [3];
  logic                          frame_start;
  bfpt_pkg::frame_stat_t         frame_stat;
  bfpt_pkg::unit_t               ex [3];
  bfpt_pkg::unit_t               ey [3];
  bfpt_pkg::unit_t               ez [3];

  logic                          v1_r, v2_r, v3_r, v4_r;
  logic                          rdy1, rdy2, rdy3, rdy4;
  logic                          last1_r, last2_r, last3_r, last4_r;
  logic signed [PW-1:0]          px_r [3];
  logic signed [PW-1:0]          py_r [3];
  logic signed [PW-1:0]          pz_r [3];
  logic signed [SW-1:0]          sum_r [3];
  logic signed [RW-1:0]          rnd_r [3];
  logic signed [COORD_WIDTH-1:0] res_r [3];
  logic                          degen4_r;
  logic                          sat4_r;

  logic [SW-1:0]                 smag [3];
  logic [SW:0]                   radd [3];
  logic signed [RW-1:0]          rnd_v [3];
  logic signed [VW-1:0]          val [3];
  logic signed [COORD_WIDTH-1:0] clip_v [3];
  logic [2:0]                    clip_f;

  // anchor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      axis_r   <= '0;
      plane_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bfpt_pkg::CFG_ORIGIN: origin_r <= cfg_wdata;
        bfpt_pkg::CFG_AXIS:   axis_r   <= cfg_wdata;
        bfpt_pkg::CFG_PLANE:  plane_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign frame_start = cfg_we && (cfg_index == bfpt_pkg::CFG_ORIGIN ||
                                  cfg_index == bfpt_pkg::CFG_AXIS ||
                                  cfg_index == bfpt_pkg::CFG_PLANE);

  // field unpack, fields cut off at the register top sign-extend
  always_comb begin
    for (int s = 0; s < 3; s++) begin
      for (int i = 0; i < COORD_WIDTH; i++) begin
        if (s * COORD_WIDTH >= CFG_W) begin
          org_c[s][i]   = 1'b0;
          axis_c[s][i]  = 1'b0;
          plane_c[s][i] = 1'b0;
        end else if (s * COORD_WIDTH + i < CFG_W) begin
          org_c[s][i]   = origin_r[s*COORD_WIDTH+i];
          axis_c[s][i]  = axis_r[s*COORD_WIDTH+i];
          plane_c[s][i] = plane_r[s*COORD_WIDTH+i];
        end else begin
          org_c[s][i]   = origin_r[CFG_W-1];
          axis_c[s][i]  = axis_r[CFG_W-1];
          plane_c[s][i] = plane_r[CFG_W-1];
        end
      end
    end
  end

  bfpt_frame #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (frame_start),
    .org_c   (org_c),
    .axis_c  (axis_c),
    .plane_c (plane_c),
    .ex_o    (ex),
    .ey_o    (ey),
    .ez_o    (ez),
    .stat_o  (frame_stat)
  );

  // pipeline flow control
  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1 && !frame_stat.busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid && in_ready;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      smag[a]  = sum_r[a][SW-1] ? SW'(-sum_r[a]) : SW'(sum_r[a]);
      radd[a]  = (SW+1)'(smag[a]) + ((SW+1)'(1) << (UB - 1));
      rnd_v[a] = sum_r[a][SW-1] ? -RW'(radd[a][SW:UB]) : RW'(radd[a][SW:UB]);
      val[a]   = VW'(rnd_r[a]) + VW'(org_c[a]);
      if (val[a] > VW'(C_HI)) begin
        clip_v[a] = C_HI;
        clip_f[a] = 1'b1;
      end else if (val[a] < VW'(C_LO)) begin
        clip_v[a] = C_LO;
        clip_f[a] = 1'b1;
      end else begin
        clip_v[a] = COORD_WIDTH'(val[a]);
        clip_f[a] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int a = 0; a < 3; a++) begin
        px_r[a] <= in_point_x * ex[a];
        py_r[a] <= in_point_y * ey[a];
        pz_r[a] <= in_point_z * ez[a];
      end
      last1_r <= in_last_point;
    end
    if (rdy2) begin
      for (int a = 0; a < 3; a++) begin
        sum_r[a] <= SW'(px_r[a]) + SW'(py_r[a]) + SW'(pz_r[a]);
      end
      last2_r <= last1_r;
    end
    if (rdy3) begin
      for (int a = 0; a < 3; a++) rnd_r[a] <= rnd_v[a];
      last3_r <= last2_r;
    end
    if (rdy4) begin
      for (int a = 0; a < 3; a++) begin
        res_r[a] <= frame_stat.degenerate ? '0 : clip_v[a];
      end
      degen4_r <= frame_stat.degenerate;
      sat4_r   <= !frame_stat.degenerate && (clip_f != 3'b000);
      last4_r  <= last3_r;
    end
  end

  assign out_valid            = v4_r;
  assign out_out_x            = res_r[0];
  assign out_out_y            = res_r[1];
  assign out_out_z            = res_r[2];
  assign out_degenerate_frame = degen4_r;
  assign out_saturated        = sat4_r;
  assign out_last_out         = last4_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    frame_start |=> frame_stat.busy)
    else $error("frame builder not busy after anchor write");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate_frame) |->
      (out_out_x == '0 && out_out_y == '0 && out_out_z == '0 && !out_saturated))
    else $error("degenerate result not zero");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_out_x == C_HI || out_out_x == C_LO || out_out_y == C_HI ||
       out_out_y == C_LO || out_out_z == C_HI || out_out_z == C_LO))
    else $error("saturated flag without a clipped coordinate");

endmodule

@@ tb/sv/bfpt_placement_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bfpt_placement_checker
// watches the anchor writes and both point channels of the frame transform,
// predicts every placed point and compares it with what comes out
// ----------------------------------------------------------------------------
module bfpt_placement_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [59:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [19:0] in_point_x,
  input  logic signed [19:0] in_point_y,
  input  logic signed [19:0] in_point_z,
  input  logic               in_last_point,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [19:0] out_out_x,
  input  logic signed [19:0] out_out_y,
  input  logic signed [19:0] out_out_z,
  input  logic               out_degenerate_frame,
  input  logic               out_saturated,
  input  logic               out_last_out,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
    logic               degen;
    logic               sat;
    logic               last;
  } placed_t;

  logic [59:0] origin_reg, axis_reg, plane_reg;
  placed_t     placed_q[$];

  function automatic longint anchor_coord(logic [59:0] r, int a);
    logic signed [19:0] c;
    c = r[20*a +: 20];
    return longint'(c);
  endfunction

  function automatic longint rnd30(longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : longint'(v);
    m = (m + (64'd1 << 29)) >> 30;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic void cross3(input longint p[3], input longint q[3],
                                 output longint r[3]);
    r[0] = p[1] * q[2] - p[2] * q[1];
    r[1] = p[2] * q[0] - p[0] * q[2];
    r[2] = p[0] * q[1] - p[1] * q[0];
  endfunction

  // q30 unit vector, 0 when the vector has no length
  function automatic bit unit_vec(input longint v[3], output longint u[3]);
    longint unsigned m[3];
    longint unsigned top, sumsq, len, rem, bitv;
    top = 0;
    sumsq = 0;
    for (int a = 0; a < 3; a++) begin
      m[a] = (v[a] < 0) ? longint'(-v[a]) : longint'(v[a]);
      if (m[a] > top) top = m[a];
      u[a] = 0;
    end
    if (top == 0) return 0;
    while (top >= (64'd1 << 30)) begin
      for (int a = 0; a < 3; a++) m[a] = m[a] >> 1;
      top = top >> 1;
    end
    while (top < (64'd1 << 29)) begin
      for (int a = 0; a < 3; a++) m[a] = m[a] << 1;
      top = top << 1;
    end
    for (int a = 0; a < 3; a++) sumsq += m[a] * m[a];
    len = 0;
    rem = sumsq;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= len + bitv) begin
        rem = rem - (len + bitv);
        len = (len >> 1) + bitv;
      end else begin
        len = len >> 1;
      end
      bitv = bitv >> 2;
    end
    for (int a = 0; a < 3; a++) begin
      u[a] = longint'(((m[a] << 30) + len / 2) / len);
      if (v[a] < 0) u[a] = -u[a];
    end
    return 1;
  endfunction

  function automatic placed_t place_point(longint px, longint py, longint pz, logic last);
    placed_t r;
    longint org[3], tow[3], acr[3], ex[3], et[3], ez[3], ey[3], raw[3];
    longint acc, val;
    bit ok;
    r.x = 0;
    r.y = 0;
    r.z = 0;
    r.sat = 0;
    r.last = last;
    for (int a = 0; a < 3; a++) begin
      org[a] = anchor_coord(origin_reg, a);
      tow[a] = anchor_coord(axis_reg, a) - org[a];
      acr[a] = anchor_coord(plane_reg, a) - org[a];
    end
    ok = unit_vec(tow, ex);
    if (ok) ok = unit_vec(acr, et);
    if (ok) begin
      cross3(ex, et, raw);
      ok = unit_vec(raw, ez);
    end
    r.degen = !ok;
    if (ok) begin
      cross3(ez, ex, raw);
      for (int a = 0; a < 3; a++) ey[a] = rnd30(raw[a]);
      for (int a = 0; a < 3; a++) begin
        acc = px * ex[a] + py * ey[a] + pz * ez[a];
        val = rnd30(acc) + org[a];
        if (val > 524287) begin
          val = 524287;
          r.sat = 1;
        end else if (val < -524288) begin
          val = -524288;
          r.sat = 1;
        end
        if (a == 0) r.x = val[19:0];
        else if (a == 1) r.y = val[19:0];
        else r.z = val[19:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    placed_t e;
    if (!rst_n) begin
      origin_reg <= '0;
      axis_reg   <= '0;
      plane_reg  <= '0;
      placed_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bfpt_pkg::CFG_ORIGIN: origin_reg <= cfg_wdata;
          bfpt_pkg::CFG_AXIS:   axis_reg   <= cfg_wdata;
          bfpt_pkg::CFG_PLANE:  plane_reg  <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        placed_q.insert(placed_q.size(),
                        place_point(in_point_x, in_point_y, in_point_z, in_last_point));
      if (out_valid && out_ready) begin
        if (placed_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = placed_q.pop_front();
          if (out_out_x !== e.x || out_out_y !== e.y || out_out_z !== e.z ||
              out_degenerate_frame !== e.degen || out_saturated !== e.sat ||
              out_last_out !== e.last) begin
            fail_count <= fail_count + 1;
            if (out_out_x !== e.x) $error("out_x expected %0d got %0d", e.x, out_out_x);
            if (out_out_y !== e.y) $error("out_y expected %0d got %0d", e.y, out_out_y);
            if (out_out_z !== e.z) $error("out_z expected %0d got %0d", e.z, out_out_z);
            if (out_degenerate_frame !== e.degen)
              $error("degenerate_frame expected %0d got %0d", e.degen, out_degenerate_frame);
            if (out_saturated !== e.sat)
              $error("saturated expected %0d got %0d", e.sat, out_saturated);
            if (out_last_out !== e.last)
              $error("last_out expected %0d got %0d", e.last, out_last_out);
          end
        end
      end
      pending <= placed_q.size();
    end
  end

endmodule

@@ tb/sv/tb_backbone_frame_point_transform.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_backbone_frame_point_transform
// drives anchor writes and point streams into the frame transform under
// random sender and receiver stalls; the checker judges every result
// ----------------------------------------------------------------------------
module tb_backbone_frame_point_transform;

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               cfg_we = 0;
  logic [1:0]         cfg_index = bfpt_pkg::CFG_ORIGIN;
  logic [59:0]        cfg_wdata = '0;
  logic               in_valid = 0;
  logic               in_ready;
  logic signed [19:0] in_point_x = 0, in_point_y = 0, in_point_z = 0;
  logic               in_last_point = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [19:0] out_out_x, out_out_y, out_out_z;
  logic               out_degenerate_frame, out_saturated, out_last_out;
  int                 fail_count, pending;
  int                 tx_idle = 0, rx_idle = 0;

  always #5 clk = ~clk;

  backbone_frame_point_transform DUT (.*);

  bfpt_placement_checker u_checker (.*);

  always @(posedge clk) out_ready <= ($urandom_range(99) >= rx_idle);

  function automatic logic [59:0] pack3(int x, int y, int z);
    logic [19:0] a, b, c;
    a = 20'(x);
    b = 20'(y);
    c = 20'(z);
    return {c, b, a};
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(3))
      0: return int'($signed(20'($urandom)));
      1: return int'($urandom_range(4000)) - 2000;
      2: return int'($urandom_range(130000)) - 65000;
      default: return $urandom_range(1) ? 524287 : -524288;
    endcase
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [59:0] data);
    @(posedge clk);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 0;
  endtask

  task automatic set_frame(logic [59:0] a, logic [59:0] b, logic [59:0] c);
    write_reg(bfpt_pkg::CFG_ORIGIN, a);
    write_reg(bfpt_pkg::CFG_AXIS, b);
    write_reg(bfpt_pkg::CFG_PLANE, c);
  endtask

  task automatic send_point(int x, int y, int z, bit last);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid      <= 1;
    in_point_x    <= 20'(x);
    in_point_y    <= 20'(y);
    in_point_z    <= 20'(z);
    in_last_point <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // wait until every placed point is back, then idle before the next step
  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;

    // zero anchors after reset give a degenerate frame
    send_point(1000, -1000, 5, 0);
    send_point(524287, -524288, 0, 1);
    drain();

    // axis-aligned frame offset from zero, extremes clip
    set_frame(pack3(100000, -100000, 0), pack3(100256, -100000, 0),
              pack3(100000, -99744, 0));
    send_point(0, 0, 0, 0);
    send_point(524287, 524287, 524287, 1);
    send_point(-524288, -524288, -524288, 0);
    send_point(524287, -524288, 1, 1);
    send_point(-1, 1, -1, 0);
    send_point(300000, -300000, 12345, 1);
    drain();

    // axis point equal to origin
    set_frame(pack3(5, 6, 7), pack3(5, 6, 7), pack3(90, -3, 2));
    send_point(77, 88, 99, 1);
    drain();
    // plane point equal to origin
    write_reg(bfpt_pkg::CFG_AXIS, pack3(400, 6, 7));
    write_reg(bfpt_pkg::CFG_PLANE, pack3(5, 6, 7));
    send_point(77, 88, 99, 0);
    drain();
    // collinear anchors
    write_reg(bfpt_pkg::CFG_PLANE, pack3(-390, 6, 7));
    send_point(-77, 88, -99, 1);
    drain();

    // anchors at the coordinate extremes; writes to the spare index do nothing
    set_frame(pack3(524287, -524288, 524287), pack3(-524288, 524287, -524288),
              pack3(524287, 524287, -524288));
    write_reg(CFG_UNUSED, {60{1'b1}});
    send_point(524287, 0, -524288, 0);
    send_point(-524288, 524287, 0, 1);
    send_point(1000, -2000, 3000, 0);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        tx_idle = 30;
        rx_idle = 67;
      end else if (ph < 6) begin
        tx_idle = 67;
        rx_idle = 30;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      set_frame(pack3(rand_coord(), rand_coord(), rand_coord()),
                pack3(rand_coord(), rand_coord(), rand_coord()),
                pack3(rand_coord(), rand_coord(), rand_coord()));
      for (int i = 0; i < 50; i++) begin
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(1)));
        // sender holds off until the pipeline is empty
        if (i == 25 && ph == 4) drain();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
